// ===== rtl/core/spq_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// spq_pkg
// shared types and codes of the sorted priority queue
// ============================================================================
package spq_pkg;

    localparam int DATA_W  = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY_POP = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL_PUSH = 2'd2;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_PUSH = 2'd1,
        CELL_POP  = 2'd2
    } cell_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t op;
        word_t    value;
        word_t    key;
    } spq_ctrl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// spq_cell
// one slot of the sorted chain: compare with the pushed key, then hold,
// take the new entry, take the left neighbor or take the right neighbor
// ============================================================================
module spq_cell
(
    input  logic               clk,
    input  spq_pkg::spq_ctrl_t ctrl,
    input  logic               occupied,
    input  logic               left_gt,
    input  spq_pkg::word_t     left_value,
    input  spq_pkg::word_t     left_key,
    input  spq_pkg::word_t     right_value,
    input  spq_pkg::word_t     right_key,
    output logic               gt,
    output spq_pkg::word_t     value,
    output spq_pkg::word_t     key
);

    spq_pkg::word_t value_reg;
    spq_pkg::word_t value_next;
    spq_pkg::word_t key_reg;
    spq_pkg::word_t key_next;

    // stored key strictly above the pushed one stays in place
    assign gt = occupied && !(key_reg <= ctrl.key);

    always_comb
    begin
        value_next = value_reg;
        key_next   = key_reg;
        unique case (ctrl.op)
            spq_pkg::CELL_PUSH:
            begin
                if (!gt)
                begin
                    if (left_gt)
                    begin
                        value_next = ctrl.value;
                        key_next   = ctrl.key;
                    end
                    else
                    begin
                        value_next = left_value;
                        key_next   = left_key;
                    end
                end
            end
            spq_pkg::CELL_POP:
            begin
                value_next = right_value;
                key_next   = right_key;
            end
            default:
            begin
                value_next = value_reg;
                key_next   = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        key_reg   <= key_next;
    end

    assign value = value_reg;
    assign key   = key_reg;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sorted_priority_queue
// bounded priority queue kept in descending key order in a chain of cells
// ============================================================================
//  channel   signals                                      handshake
//  command   cmd, item_value, item_key                    start && !busy
//  result    top_value, top_key, is_empty, fill_count,    done (one cycle)
//            status
//
//  one command per clock; its result is shown in the cycle after acceptance
//  the single compare-and-shift step in every cell sets that figure
//  busy stays low, so a command may follow in every cycle
//  reset empties the queue; slot contents are not cleared
//  the receiver cannot stall; done marks each result for one cycle only
// ============================================================================
module sorted_priority_queue
#(
    parameter int DEPTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [spq_pkg::CMD_W-1:0]     cmd,
    input  logic signed [spq_pkg::DATA_W-1:0] item_value,
    input  logic signed [spq_pkg::DATA_W-1:0] item_key,
    output logic                          done,
    output logic signed [spq_pkg::DATA_W-1:0] top_value,
    output logic signed [spq_pkg::DATA_W-1:0] top_key,
    output logic                          is_empty,
    output logic [spq_pkg::FILL_W-1:0]    fill_count,
    output logic [spq_pkg::STAT_W-1:0]    status
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic                        accept;
    spq_pkg::spq_ctrl_t          ctrl;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [spq_pkg::STAT_W-1:0]  status_reg;
    logic [spq_pkg::STAT_W-1:0]  status_next;
    logic                        done_reg;

    logic                        cell_gt    [DEPTH];
    spq_pkg::word_t              cell_value [DEPTH];
    spq_pkg::word_t              cell_key   [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        ctrl.op     = spq_pkg::CELL_HOLD;
        ctrl.value  = item_value;
        ctrl.key    = item_key;
        count_next  = count_reg;
        status_next = spq_pkg::ST_OK;
        if (accept)
        begin
            unique case (cmd)
                spq_pkg::CMD_PUSH:
                begin
                    if (count_reg == CNT_FULL)
                    begin
                        status_next = spq_pkg::ST_FULL_PUSH;
                    end
                    else
                    begin
                        ctrl.op    = spq_pkg::CELL_PUSH;
                        count_next = count_reg + 1'b1;
                    end
                end
                spq_pkg::CMD_POP:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = spq_pkg::ST_EMPTY_POP;
                    end
                    else
                    begin
                        ctrl.op    = spq_pkg::CELL_POP;
                        count_next = count_reg - 1'b1;
                    end
                end
                spq_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= spq_pkg::ST_OK;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
            if (accept)
            begin
                status_reg <= status_next;
            end
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic           occ;
        logic           lgt;
        spq_pkg::word_t lval;
        spq_pkg::word_t lkey;
        spq_pkg::word_t rval;
        spq_pkg::word_t rkey;

        assign occ = count_reg > CNT_W'(i);

        if (i == 0)
        begin : g_head
            assign lgt  = 1'b1;
            assign lval = item_value;
            assign lkey = item_key;
        end
        else
        begin : g_body
            assign lgt  = cell_gt[i-1];
            assign lval = cell_value[i-1];
            assign lkey = cell_key[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign rval = cell_value[i];
            assign rkey = cell_key[i];
        end
        else
        begin : g_inner
            assign rval = cell_value[i+1];
            assign rkey = cell_key[i+1];
        end

        spq_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (occ),
            .left_gt     (lgt),
            .left_value  (lval),
            .left_key    (lkey),
            .right_value (rval),
            .right_key   (rkey),
            .gt          (cell_gt[i]),
            .value       (cell_value[i]),
            .key         (cell_key[i])
        );
    end

    assign done       = done_reg;
    assign is_empty   = (count_reg == '0);
    assign top_value  = is_empty ? '0 : cell_value[0];
    assign top_key    = is_empty ? '0 : cell_key[0];
    assign fill_count = spq_pkg::FILL_W'(count_reg);
    assign status     = status_reg;

    // every accepted transaction gives a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after accepted transaction");

    // occupancy stays within the chain
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("occupancy beyond depth");

    // a refused push only happens on a full queue, which stays full
    a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        done && status_reg == spq_pkg::ST_FULL_PUSH |-> count_reg == CNT_FULL)
        else $error("push refused while not full");

    // a successful push grows the queue by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == spq_pkg::CMD_PUSH && count_reg != CNT_FULL
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow the queue");

endmodule
